FILE: hw/rtl/accel_sample_overwrite_fifo_core_macros.svh
// Assertion helpers for the overwriting sample FIFO.
`ifndef ACCEL_SAMPLE_OVERWRITE_FIFO_CORE_MACROS_SVH
`define ACCEL_SAMPLE_OVERWRITE_FIFO_CORE_MACROS_SVH

// Checked only outside reset.
`define ASOF_ASSERT_RUN(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: label failed");

// Checked in every cycle, reset included.
`define ASOF_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: label failed");

`endif

FILE: hw/rtl/asof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asof_pkg;

    localparam int FIFO_DEPTH_DEF = 8;
    localparam int AXIS_W         = 16;
    localparam int FILL_W         = 4;
    localparam int OVR_W          = 8;
    localparam int SHIFT_W        = 2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [AXIS_W-1:0] axis_x_raw;
        logic signed [AXIS_W-1:0] axis_y_raw;
        logic signed [AXIS_W-1:0] axis_z_raw;
    } asof_in_t;

    typedef struct packed {
        logic                     status;
        logic signed [AXIS_W-1:0] sample_x;
        logic signed [AXIS_W-1:0] sample_y;
        logic signed [AXIS_W-1:0] sample_z;
        logic [FILL_W-1:0]        fill_level;
        logic [OVR_W-1:0]         overwrites;
    } asof_out_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } asof_sample_t;

    // controller -> datapath
    typedef struct packed {
        logic take;      // input word accepted this cycle
        logic load_mem;  // load result from registered memory read
    } asof_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pop_data;  // offered word is a pop that will find data
        logic out_valid;
    } asof_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/accel_sample_overwrite_fifo_core.sv
// Overwriting ring FIFO of three-axis accelerometer samples. A push word
// stores its three axes, each shifted right arithmetically by the 2-bit
// scale setting, and drops the oldest entry when all FIFO_DEPTH entries are
// in use (the 8-bit overwrite count then wraps forward). A pop word returns
// the oldest entry, or status 1 with zero samples when empty. Every result
// word carries the fill level (low 4 bits) and the overwrite count. A push
// or an empty pop goes straight to the output register; a pop with data
// first passes the registered sample memory read. A new word can enter in
// the cycle the held result is taken; input is held off while a result
// waits unread or a pop's memory read is under way. The user writes the
// scale setting via cfg_wr_en/cfg_wr_data only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module accel_sample_overwrite_fifo_core
    import asof_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [SHIFT_W-1:0] cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire asof_in_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output asof_out_t               m_data
);

    asof_cmd_t  cmd;
    asof_stat_t stat;

    asof_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    asof_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat),
        .m_data      (m_data)
    );

    assign m_valid = stat.out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/asof_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module asof_ctrl
    import asof_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       m_ready,
    input  wire asof_stat_t stat,
    output asof_cmd_t       cmd,
    output logic            s_ready
);

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_POP    = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        s_ready      = (state_reg == ST_ACCEPT) && (!stat.out_valid || m_ready);
        cmd.take     = s_valid && s_ready;
        cmd.load_mem = (state_reg == ST_POP);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCEPT: begin
                if (cmd.take && stat.pop_data) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                state_next = ST_ACCEPT;
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/asof_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module asof_datapath
    import asof_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [SHIFT_W-1:0] cfg_wr_data,
    input  wire asof_in_t           s_data,
    input  wire logic               m_ready,
    input  wire asof_cmd_t          cmd,
    output asof_stat_t              stat,
    output asof_out_t               m_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    asof_sample_t mem [FIFO_DEPTH];
    asof_sample_t rd_data_reg;
    asof_sample_t wr_sample;

    logic [SHIFT_W-1:0] scale_shift_reg;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [OVR_W-1:0]   lost_reg, lost_next;
    logic               out_valid_reg, out_valid_next;
    asof_out_t          out_data_reg, out_data_next;
    logic               is_push;
    logic               is_pop;

    assign is_push = cmd.take && (s_data.command == CMD_PUSH);
    assign is_pop  = cmd.take && stat.pop_data;

    assign stat.pop_data  = (s_data.command == CMD_POP) && (cnt_reg != '0);
    assign stat.out_valid = out_valid_reg;
    assign m_data         = out_data_reg;

    always_comb begin
        wr_sample.x = s_data.axis_x_raw >>> scale_shift_reg;
        wr_sample.y = s_data.axis_y_raw >>> scale_shift_reg;
        wr_sample.z = s_data.axis_z_raw >>> scale_shift_reg;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        lost_next   = lost_reg;
        if (is_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (cnt_reg == CNT_FULL) begin
                rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                lost_next   = lost_reg + 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end else if (is_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (cmd.load_mem) begin
            out_valid_next           = 1'b1;
            out_data_next.status     = STATUS_OK;
            out_data_next.sample_x   = rd_data_reg.x;
            out_data_next.sample_y   = rd_data_reg.y;
            out_data_next.sample_z   = rd_data_reg.z;
            out_data_next.fill_level = FILL_W'(cnt_reg);
            out_data_next.overwrites = lost_reg;
        end else if (cmd.take && !stat.pop_data) begin
            out_valid_next           = 1'b1;
            out_data_next.status     = (s_data.command == CMD_POP) ? STATUS_EMPTY : STATUS_OK;
            out_data_next.sample_x   = '0;
            out_data_next.sample_y   = '0;
            out_data_next.sample_z   = '0;
            out_data_next.fill_level = FILL_W'(cnt_next);
            out_data_next.overwrites = lost_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_push) begin
            mem[wr_ptr_reg] <= wr_sample;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_shift_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            cnt_reg         <= '0;
            lost_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                scale_shift_reg <= cfg_wr_data;
            end
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/asof_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "accel_sample_overwrite_fifo_core_macros.svh"

module asof_checker
    import asof_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire asof_in_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire asof_out_t m_data
);

    logic push_take;
    logic push_word_ok;
    logic empty_held;

    assign push_take    = s_valid && s_ready && (s_data.command == CMD_PUSH);
    assign push_word_ok = m_valid && (m_data.status == STATUS_OK)
                          && (m_data.sample_x == '0) && (m_data.sample_y == '0)
                          && (m_data.sample_z == '0);
    assign empty_held   = m_valid && (m_data.status == STATUS_EMPTY) && !m_ready;

    // held result word stays put
    `ASOF_ASSERT_RUN(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // push result shows up in the next cycle, ok and with zero samples
    `ASOF_ASSERT_RUN(a_push_result, aclk, aresetn, push_take, push_word_ok)

    // a pop that finds nothing reports an empty FIFO
    `ASOF_ASSERT_RUN(a_empty_pop, aclk, aresetn, empty_held, m_data.fill_level == '0)

    // nothing leaves right after reset
    `ASOF_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_valid)

endmodule

bind accel_sample_overwrite_fifo_core asof_checker u_asof_checker (.*);

`default_nettype wire
